[rtl/ltsd_pkg.sv]
// Package for the token splitter: lexer state and class codes, emission
// symbols, the transition/emission table and character helpers.
// No dependencies.
package ltsd_pkg;

    localparam int CH_W = 16;

    localparam logic [CH_W-1:0] CH_NL    = 16'h000A;
    localparam logic [CH_W-1:0] CH_SPACE = 16'h0020;
    localparam logic [CH_W-1:0] CH_STAR  = 16'h002A;
    localparam logic [CH_W-1:0] CH_PLUS  = 16'h002B;
    localparam logic [CH_W-1:0] CH_MINUS = 16'h002D;
    localparam logic [CH_W-1:0] CH_DOT   = 16'h002E;
    localparam logic [CH_W-1:0] CH_SLASH = 16'h002F;
    localparam logic [CH_W-1:0] CH_ZERO  = 16'h0030;
    localparam logic [CH_W-1:0] CH_NINE  = 16'h0039;
    localparam logic [CH_W-1:0] CH_LT    = 16'h003C;
    localparam logic [CH_W-1:0] CH_EQ    = 16'h003D;
    localparam logic [CH_W-1:0] CH_GT    = 16'h003E;

    typedef enum logic [3:0] {
        ST_START     = 4'd0,
        ST_IDENT     = 4'd1,
        ST_IDENT_DIG = 4'd2,
        ST_INT       = 4'd3,
        ST_FRAC      = 4'd4,
        ST_SLASH     = 4'd5,
        ST_CMT       = 4'd6,
        ST_CMT_STAR  = 4'd7,
        ST_EQ        = 4'd8,
        ST_GT        = 4'd9,
        ST_LT        = 4'd10,
        ST_SPACE     = 4'd11
    } t_lex_state;

    typedef enum logic [3:0] {
        CL_DIGIT = 4'd0,
        CL_DOT   = 4'd1,
        CL_PM    = 4'd2,
        CL_EQ    = 4'd3,
        CL_GT    = 4'd4,
        CL_LT    = 4'd5,
        CL_SLASH = 4'd6,
        CL_STAR  = 4'd7,
        CL_SPACE = 4'd8,
        CL_OTHER = 4'd9
    } t_cls;

    // SYM_IN stands for the input character itself
    typedef enum logic [2:0] {
        SYM_NL    = 3'd0,
        SYM_IN    = 3'd1,
        SYM_DOT   = 3'd2,
        SYM_STAR  = 3'd3,
        SYM_SLASH = 3'd4,
        SYM_EQ    = 3'd5,
        SYM_GT    = 3'd6,
        SYM_LT    = 3'd7
    } t_sym;

    typedef struct packed {
        logic [1:0]     last_idx;
        t_sym [3:0]     sym;
    } t_cmd;

    typedef struct packed {
        t_lex_state next;
        logic [2:0] cnt;
        t_cmd       cmd;
    } t_cell;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic t_cls classify(logic [CH_W-1:0] c);
        t_cls r;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r = CL_DIGIT;
        end else begin
            case (c)
                CH_DOT:            r = CL_DOT;
                CH_PLUS, CH_MINUS: r = CL_PM;
                CH_EQ:             r = CL_EQ;
                CH_GT:             r = CL_GT;
                CH_LT:             r = CL_LT;
                CH_SLASH:          r = CL_SLASH;
                CH_STAR:           r = CL_STAR;
                CH_SPACE:          r = CL_SPACE;
                default:           r = CL_OTHER;
            endcase
        end
        return r;
    endfunction

    function automatic t_cell mk(t_lex_state nx, logic [2:0] n,
                                 t_sym s0, t_sym s1, t_sym s2, t_sym s3);
        t_cell r;
        r.next         = nx;
        r.cnt          = n;
        r.cmd.last_idx = (n == 3'd0) ? 2'd0 : 2'(n - 3'd1);
        r.cmd.sym[0]   = s0;
        r.cmd.sym[1]   = s1;
        r.cmd.sym[2]   = s2;
        r.cmd.sym[3]   = s3;
        return r;
    endfunction

    function automatic t_cell silent(t_lex_state nx);
        return mk(nx, 3'd0, SYM_NL, SYM_NL, SYM_NL, SYM_NL);
    endfunction

    // Next state and emission for one character
    function automatic t_cell lookup(t_lex_state st, t_cls cl);
        t_cell r;
        t_sym  p;
        p = SYM_EQ;
        case (st)
            ST_IDENT, ST_IDENT_DIG, ST_INT, ST_FRAC: begin
                case (cl)
                    CL_DIGIT: r = mk((st == ST_IDENT) ? ST_IDENT_DIG : st, 3'd1,
                                     SYM_IN, SYM_NL, SYM_NL, SYM_NL);
                    CL_DOT:   r = (st == ST_INT)
                                  ? mk(ST_FRAC, 3'd1, SYM_DOT, SYM_NL, SYM_NL, SYM_NL)
                                  : mk(ST_FRAC, 3'd2, SYM_NL, SYM_DOT, SYM_NL, SYM_NL);
                    CL_PM:    r = mk(ST_START, 3'd3, SYM_NL, SYM_IN, SYM_NL, SYM_NL);
                    CL_EQ:    r = mk(ST_EQ, 3'd1, SYM_NL, SYM_NL, SYM_NL, SYM_NL);
                    CL_GT:    r = mk(ST_GT, 3'd1, SYM_NL, SYM_NL, SYM_NL, SYM_NL);
                    CL_LT:    r = mk(ST_LT, 3'd1, SYM_NL, SYM_NL, SYM_NL, SYM_NL);
                    CL_SLASH: r = mk(ST_SLASH, 3'd1, SYM_NL, SYM_NL, SYM_NL, SYM_NL);
                    CL_STAR:  r = mk(ST_START, 3'd3, SYM_NL, SYM_STAR, SYM_NL, SYM_NL);
                    CL_SPACE: r = mk(ST_SPACE, 3'd1, SYM_NL, SYM_NL, SYM_NL, SYM_NL);
                    default: begin
                        if (st == ST_INT || st == ST_FRAC) begin
                            r = mk(ST_IDENT, 3'd2, SYM_NL, SYM_IN, SYM_NL, SYM_NL);
                        end else begin
                            r = mk(st, 3'd1, SYM_IN, SYM_NL, SYM_NL, SYM_NL);
                        end
                    end
                endcase
            end
            ST_SLASH: begin
                // a pending slash is dropped before +, -, =, <, > and another slash
                case (cl)
                    CL_DIGIT: r = mk(ST_INT, 3'd3, SYM_SLASH, SYM_NL, SYM_IN, SYM_NL);
                    CL_DOT:   r = mk(ST_FRAC, 3'd3, SYM_SLASH, SYM_NL, SYM_DOT, SYM_NL);
                    CL_PM:    r = mk(ST_START, 3'd2, SYM_IN, SYM_NL, SYM_NL, SYM_NL);
                    CL_EQ:    r = mk(ST_EQ, 3'd1, SYM_NL, SYM_NL, SYM_NL, SYM_NL);
                    CL_GT:    r = mk(ST_GT, 3'd1, SYM_NL, SYM_NL, SYM_NL, SYM_NL);
                    CL_LT:    r = mk(ST_LT, 3'd1, SYM_NL, SYM_NL, SYM_NL, SYM_NL);
                    CL_SLASH: r = mk(ST_SLASH, 3'd1, SYM_NL, SYM_NL, SYM_NL, SYM_NL);
                    CL_STAR:  r = silent(ST_CMT);
                    CL_SPACE: r = mk(ST_SPACE, 3'd2, SYM_SLASH, SYM_NL, SYM_NL, SYM_NL);
                    default:  r = mk(ST_IDENT, 3'd3, SYM_SLASH, SYM_NL, SYM_IN, SYM_NL);
                endcase
            end
            ST_CMT: begin
                r = (cl == CL_STAR) ? silent(ST_CMT_STAR) : silent(ST_CMT);
            end
            ST_CMT_STAR: begin
                case (cl)
                    CL_DOT:   r = silent(ST_FRAC);
                    CL_SLASH: r = silent(ST_START);
                    CL_STAR:  r = silent(ST_CMT_STAR);
                    CL_SPACE: r = silent(ST_IDENT);
                    default:  r = silent(ST_CMT);
                endcase
            end
            ST_EQ, ST_GT, ST_LT: begin
                if (st == ST_GT) begin
                    p = SYM_GT;
                end else if (st == ST_LT) begin
                    p = SYM_LT;
                end
                case (cl)
                    CL_DIGIT: r = mk(ST_INT, 3'd3, p, SYM_NL, SYM_IN, SYM_NL);
                    CL_DOT:   r = mk(ST_FRAC, 3'd3, p, SYM_NL, SYM_DOT, SYM_NL);
                    CL_PM:    r = mk(ST_START, 3'd4, p, SYM_NL, SYM_IN, SYM_NL);
                    CL_EQ:    r = mk(ST_START, 3'd3, p, SYM_EQ, SYM_NL, SYM_NL);
                    CL_GT:    r = mk(ST_GT, 3'd2, p, SYM_NL, SYM_NL, SYM_NL);
                    CL_LT:    r = mk(ST_LT, 3'd2, p, SYM_NL, SYM_NL, SYM_NL);
                    CL_SLASH: r = mk(ST_SLASH, 3'd2, p, SYM_NL, SYM_NL, SYM_NL);
                    CL_STAR:  r = mk(ST_START, 3'd4, p, SYM_NL, SYM_STAR, SYM_NL);
                    CL_SPACE: r = mk(ST_SPACE, 3'd2, p, SYM_NL, SYM_NL, SYM_NL);
                    default:  r = mk(ST_IDENT, 3'd3, p, SYM_NL, SYM_IN, SYM_NL);
                endcase
            end
            default: begin
                // start, after space, and unused codes (which act as start)
                case (cl)
                    CL_DIGIT: r = mk(ST_INT, 3'd1, SYM_IN, SYM_NL, SYM_NL, SYM_NL);
                    CL_DOT:   r = mk(ST_FRAC, 3'd1, SYM_IN, SYM_NL, SYM_NL, SYM_NL);
                    CL_PM:    r = mk(ST_START, 3'd2, SYM_IN, SYM_NL, SYM_NL, SYM_NL);
                    CL_EQ:    r = silent(ST_EQ);
                    CL_GT:    r = silent(ST_GT);
                    CL_LT:    r = silent(ST_LT);
                    CL_SLASH: r = silent(ST_SLASH);
                    CL_STAR:  r = mk(ST_START, 3'd2, SYM_STAR, SYM_NL, SYM_NL, SYM_NL);
                    CL_SPACE: r = (st == ST_SPACE)
                                  ? silent(ST_SPACE)
                                  : mk(ST_SPACE, 3'd1, SYM_NL, SYM_NL, SYM_NL, SYM_NL);
                    default:  r = mk(ST_IDENT, 3'd1, SYM_IN, SYM_NL, SYM_NL, SYM_NL);
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic logic [CH_W-1:0] sym2char(t_sym s, logic [CH_W-1:0] c);
        logic [CH_W-1:0] r;
        case (s)
            SYM_NL:    r = CH_NL;
            SYM_IN:    r = c;
            SYM_DOT:   r = CH_DOT;
            SYM_STAR:  r = CH_STAR;
            SYM_SLASH: r = CH_SLASH;
            SYM_EQ:    r = CH_EQ;
            SYM_GT:    r = CH_GT;
            SYM_LT:    r = CH_LT;
            default:   r = CH_NL;
        endcase
        return r;
    endfunction

endpackage

[rtl/ltsd_channels.sv]
// Valid/ready channel interfaces: character input and token character output.
// Depends on ltsd_pkg for the character width.
interface ltsd_char_if;
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [ltsd_pkg::CH_W-1:0] ch;

    modport source (output valid, output op, output ch, input ready);
    modport sink   (input valid, input op, input ch, output ready);
endinterface

interface ltsd_tok_if;
    logic                      valid;
    logic                      ready;
    logic [ltsd_pkg::CH_W-1:0] out_char;
    logic                      last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

[rtl/ltsd_front.sv]
// Front end: accepts characters, classifies them, steps the lexer state and
// pushes an emission command into the queue. Depends on ltsd_pkg, ltsd_channels.
module ltsd_front #(
    parameter int CW = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    ltsd_char_if.sink                i_char,
    input  ltsd_pkg::t_qstat         i_qstat,
    output logic                     o_push,
    output logic [CW-1:0]            o_push_ch,
    output ltsd_pkg::t_cmd           o_push_cmd
);

    ltsd_pkg::t_lex_state r_state;
    ltsd_pkg::t_lex_state n_state;
    ltsd_pkg::t_cell      lex_step;
    logic [CW-1:0]        cm;
    logic                 eot;
    logic                 acc;

    assign i_char.ready = !i_qstat.full;
    assign acc          = i_char.valid && i_char.ready;
    assign cm           = i_char.ch[CW-1:0];
    assign eot          = i_char.op || (cm == '0);

    always_comb begin
        lex_step = ltsd_pkg::lookup(r_state, ltsd_pkg::classify(ltsd_pkg::CH_W'(cm)));
        if (eot) begin
            // end of text: one newline, any pending operator or comment dropped
            lex_step = ltsd_pkg::mk(ltsd_pkg::ST_START, 3'd1, ltsd_pkg::SYM_NL,
                                    ltsd_pkg::SYM_NL, ltsd_pkg::SYM_NL, ltsd_pkg::SYM_NL);
        end
        n_state    = acc ? lex_step.next : r_state;
        o_push     = acc && (lex_step.cnt != 3'd0);
        o_push_ch  = cm;
        o_push_cmd = lex_step.cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ltsd_pkg::ST_START;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/ltsd_queue.sv]
// Small FIFO of emission commands between front and back end.
// Depends on ltsd_pkg for the status struct.
module ltsd_queue #(
    parameter int W     = 16,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [W-1:0]     i_wdata,
    input  logic             i_pop,
    output logic [W-1:0]     o_rdata,
    output ltsd_pkg::t_qstat o_qstat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    logic [W-1:0]   r_mem [DEPTH];
    logic [PW-1:0]  r_wptr, n_wptr;
    logic [PW-1:0]  r_rptr, n_rptr;
    logic [CNW-1:0] r_cnt, n_cnt;
    logic           do_push, do_pop;

    assign o_qstat.full  = (r_cnt == CNW'(DEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign do_push       = i_push && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;
    assign o_rdata       = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

[rtl/ltsd_back.sv]
// Back end: walks the head command of the queue one character per cycle while
// o_tok is ready, into a registered output stage. Depends on ltsd_pkg, ltsd_channels.
module ltsd_back #(
    parameter int CW = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CW-1:0]    i_head_ch,
    input  ltsd_pkg::t_cmd   i_head_cmd,
    input  ltsd_pkg::t_qstat i_qstat,
    output logic             o_pop,
    ltsd_tok_if.source       o_tok
);

    logic                      r_valid, n_valid;
    logic [ltsd_pkg::CH_W-1:0] r_char, n_char;
    logic                      r_last, n_last;
    logic [1:0]                r_pos, n_pos;
    logic                      load;
    logic                      at_end;

    assign o_tok.valid    = r_valid;
    assign o_tok.out_char = r_char;
    assign o_tok.last     = r_last;

    assign load   = !r_valid || o_tok.ready;
    assign at_end = (r_pos == i_head_cmd.last_idx);

    always_comb begin
        n_valid = r_valid;
        n_char  = r_char;
        n_last  = r_last;
        n_pos   = r_pos;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = !i_qstat.empty;
            if (!i_qstat.empty) begin
                n_char = ltsd_pkg::sym2char(i_head_cmd.sym[r_pos],
                                            ltsd_pkg::CH_W'(i_head_ch));
                n_last = at_end;
                n_pos  = at_end ? 2'd0 : r_pos + 2'd1;
                o_pop  = at_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
    end

endmodule

[rtl/lexer_token_splitter_dfa.sv]
// Top level of the token splitter: front end, command queue, back end.
// Depends on ltsd_pkg, ltsd_channels, ltsd_front, ltsd_queue, ltsd_back.
//
// Input channel i_char carries one character (ch) or an end-of-text mark (op,
// or a character code of zero). Output channel o_tok carries the token stream
// one character per transfer; tokens are separated by newlines and last marks
// the final character produced for an input item. Items that produce nothing
// (operator prefixes, comment text, repeated spaces) cause no transfer.
//
// Throughput: one input item per cycle while the queue has room; the output
// runs at one character per cycle while o_tok is ready, so items that expand
// into two to four characters are limited by the back end walking the queued
// command. The first character of an item is queued as part of its command
// when the item is accepted, and is then registered into the output stage
// once the output register is free.
// When o_tok stalls, the output register holds and the queue of QUEUE_DEPTH
// commands fills; i_char.ready drops only when the queue is full.
// Reset (synchronous, active low) returns the lexer to its start state and
// empties the queue and the output register.
module lexer_token_splitter_dfa #(
    parameter int CHAR_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ltsd_char_if.sink   i_char,
    ltsd_tok_if.source  o_tok
);

    localparam int CW = (CHAR_BITS < ltsd_pkg::CH_W) ? CHAR_BITS : ltsd_pkg::CH_W;
    localparam int QW = CW + $bits(ltsd_pkg::t_cmd);

    logic             push;
    logic [CW-1:0]    push_ch;
    ltsd_pkg::t_cmd   push_cmd;
    logic             pop;
    logic [QW-1:0]    head;
    ltsd_pkg::t_qstat qstat;

    ltsd_front #(.CW(CW)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_char     (i_char),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_push_ch  (push_ch),
        .o_push_cmd (push_cmd)
    );

    ltsd_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata ({push_ch, push_cmd}),
        .i_pop   (pop),
        .o_rdata (head),
        .o_qstat (qstat)
    );

    ltsd_back #(.CW(CW)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head_ch  (head[QW-1 -: CW]),
        .i_head_cmd (ltsd_pkg::t_cmd'(head[$bits(ltsd_pkg::t_cmd)-1:0])),
        .i_qstat    (qstat),
        .o_pop      (pop),
        .o_tok      (o_tok)
    );

endmodule

[rtl/ltsd_checker.sv]
// Port-level checks for the token splitter, bound to the top level.
// Depends on ltsd_pkg and lexer_token_splitter_dfa.
module ltsd_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [ltsd_pkg::CH_W-1:0] i_out_char,
    input logic                      i_out_last
);

    // stalled output holds its character
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char)
                                        && $stable(i_out_last))
        else $error("output changed while stalled");

    // a token burst runs without gaps until its last character
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> i_out_valid)
        else $error("gap inside an item's characters");

    // code zero is end of text, never an emitted character
    a_no_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_char != '0)
        else $error("zero character emitted");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind lexer_token_splitter_dfa ltsd_checker u_ltsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_tok.valid),
    .i_out_ready (o_tok.ready),
    .i_out_char  (o_tok.out_char),
    .i_out_last  (o_tok.last)
);
